/* src/tmps_pkg.sv */
`default_nettype none

package tmps_pkg;

	// samples per window
	localparam int WINDOW = 40;

	localparam int SAMPLE_W = 12;
	localparam int SUM_W    = 20;
	localparam int CNT_W    = 8;
	localparam int Q8_W     = 20;
	localparam int GAIN_W   = 20;
	localparam int OFFS_W   = 15;
	localparam int PH_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 40;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd294697;

	// trimmed mean only when there are enough samples to drop two
	localparam bit TRIM = (WINDOW >= 5);

	// constant divide: q = (x * DIV_M) >> DIV_S, then one correction step
	localparam int DIV_X_W  = 28;
	localparam int DIV_S    = DIV_X_W;
	localparam int DIV_D_I  = TRIM ? WINDOW - 2 : WINDOW;
	localparam int DIV_M_W  = DIV_S + 1;
	localparam int M_LO_W   = 15;
	localparam int M_HI_W   = DIV_M_W - M_LO_W;
	localparam logic [DIV_M_W-1:0] DIV_M =
		DIV_M_W'((longint'(1) << DIV_S) / longint'(DIV_D_I));
	localparam logic [CNT_W-1:0] DIV_D = CNT_W'(DIV_D_I);
	localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(WINDOW - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PH_GAIN   = 2'd0,
		CFG_PH_OFFSET = 2'd1
	} cfg_idx_t;

	// one finished window travelling from front to back
	typedef struct packed {
		logic [SUM_W-1:0]    sum;
		logic [SAMPLE_W-1:0] min;
		logic [SAMPLE_W-1:0] max;
	} window_t;

endpackage

`default_nettype wire

/* src/tmps_front.sv */
`default_nettype none

module tmps_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            take,
	input  wire logic [tmps_pkg::SAMPLE_W-1:0]   sample,
	output logic                                 push,
	output tmps_pkg::window_t                    win
);
	import tmps_pkg::*;

	logic [CNT_W-1:0]    count_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;

	logic [SUM_W-1:0]    sum_nx;
	logic [SAMPLE_W-1:0] min_nx;
	logic [SAMPLE_W-1:0] max_nx;
	logic                last;

	always_comb begin
		sum_nx = sum_q + SUM_W'(sample);
		min_nx = (sample < min_q) ? sample : min_q;
		max_nx = (sample > max_q) ? sample : max_q;
		last   = (count_q == LAST_CNT);
		push   = take && last;
		win.sum = sum_nx;
		win.min = min_nx;
		win.max = max_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
		end else if (take) begin
			if (last) begin
				count_q <= '0;
				sum_q   <= '0;
				min_q   <= '1;
				max_q   <= '0;
			end else begin
				count_q <= count_q + 1'b1;
				sum_q   <= sum_nx;
				min_q   <= min_nx;
				max_q   <= max_nx;
			end
		end
	end

endmodule

`default_nettype wire

/* src/tmps_fifo.sv */
`default_nettype none

module tmps_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire tmps_pkg::window_t  wr_win,
	input  wire logic               pop,
	output tmps_pkg::window_t       rd_win,
	output logic                    empty,
	output logic                    full
);
	import tmps_pkg::*;

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	window_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [PTR_W:0]     fill_q;

	assign empty  = (fill_q == '0);
	assign full   = (fill_q == (PTR_W+1)'(DEPTH));
	assign rd_win = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_win;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/tmps_back.sv */
`default_nettype none

module tmps_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tmps_pkg::window_t              win,
	input  wire logic                           win_avail,
	output logic                                win_pop,
	input  wire logic [tmps_pkg::GAIN_W-1:0]    gain,
	input  wire logic [tmps_pkg::OFFS_W-1:0]    offset,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [tmps_pkg::Q8_W-1:0]           mean_q8,
	output logic [tmps_pkg::PH_W-1:0]           ph_milli
);
	import tmps_pkg::*;

	localparam int PL_W   = DIV_X_W + M_LO_W;
	localparam int PH_PW  = DIV_X_W + M_HI_W;
	localparam int FULL_W = DIV_X_W + DIV_M_W;
	localparam int PROD_W = Q8_W + GAIN_W;
	localparam int PHS_W  = PH_W + 2;

	localparam logic [M_LO_W-1:0] M_LO = DIV_M[M_LO_W-1:0];
	localparam logic [M_HI_W-1:0] M_HI = DIV_M[DIV_M_W-1:M_LO_W];

	logic adv;
	logic v1_s1, v2_s2, v3_s3, v4_s4;

	logic [DIV_X_W-1:0] x_in;
	logic [SUM_W-1:0]   trimmed;

	logic [DIV_X_W-1:0] x_s1;
	logic [PL_W-1:0]    pl_s1;
	logic [PH_PW-1:0]   ph_s1;

	logic [FULL_W-1:0]  full_prod;
	logic [DIV_X_W-1:0] x_s2;
	logic [DIV_X_W-1:0] q_s2;

	logic [DIV_X_W-1:0] rem;
	logic [DIV_X_W-1:0] q_fix;
	logic [Q8_W-1:0]    mean_s3;

	logic [Q8_W-1:0]    mean_s4;
	logic [PROD_W-1:0]  prod_s4;

	logic signed [PHS_W-1:0] ph_sum;
	logic [PH_W-1:0]         ph_sat;

	// whole pipe moves when the output register is free or being taken
	assign adv     = !out_valid || out_ready;
	assign win_pop = adv && win_avail;

	always_comb begin
		trimmed = win.sum - SUM_W'(win.min) - SUM_W'(win.max);
		if (TRIM) begin
			x_in = {trimmed, 8'd0};
		end else begin
			x_in = DIV_X_W'(win.sum);
		end
	end

	// estimate is exact or one low; remainder check fixes it
	always_comb begin
		full_prod = (FULL_W'(ph_s1) << M_LO_W) + FULL_W'(pl_s1);
		rem       = x_s2 - DIV_X_W'(q_s2 * DIV_D);
		q_fix     = (rem >= DIV_X_W'(DIV_D)) ? q_s2 + 1'b1 : q_s2;
	end

	always_comb begin
		ph_sum = $signed({2'b00, prod_s4[PROD_W-1:24]})
			+ PHS_W'($signed(offset));
		if (ph_sum > PHS_W'(32767)) begin
			ph_sat = 16'h7FFF;
		end else if (ph_sum < -PHS_W'(32768)) begin
			ph_sat = 16'h8000;
		end else begin
			ph_sat = ph_sum[PH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1    <= x_in;
			pl_s1   <= PL_W'(x_in) * PL_W'(M_LO);
			ph_s1   <= PH_PW'(x_in) * PH_PW'(M_HI);
			x_s2    <= x_s1;
			q_s2    <= full_prod[DIV_S +: DIV_X_W];
			if (TRIM) begin
				mean_s3 <= q_fix[Q8_W-1:0];
			end else begin
				mean_s3 <= {q_fix[Q8_W-9:0], 8'd0};
			end
			mean_s4  <= mean_s3;
			prod_s4  <= PROD_W'(mean_s3) * PROD_W'(gain);
			mean_q8  <= mean_s4;
			ph_milli <= ph_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1     <= 1'b0;
			v2_s2     <= 1'b0;
			v3_s3     <= 1'b0;
			v4_s4     <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			v1_s1     <= win_avail;
			v2_s2     <= v1_s1;
			v3_s3     <= v2_s2;
			v4_s4     <= v3_s3;
			out_valid <= v4_s4;
		end
	end

endmodule

`default_nettype wire

/* src/trimmed_mean_ph_sampler_unit.sv */
// Trimmed-mean pH sampler.
// Input stream s_*: one word per 12-bit ADC sample (s_tdata[11:0]). Samples are
// taken one per cycle; s_tready drops only while the window queue is full.
// Every WINDOW samples (package constant, 40) the front closes a window: sum,
// minimum and maximum go into a 4-deep queue and the accumulators clear.
// The back drops one min and one max, divides by WINDOW-2 with a reciprocal
// multiply (two partial products, then a remainder correction), scales by
// ph_gain, adds ph_offset_milli and saturates. WINDOW below 5 gives the plain
// truncated mean instead.
// Output stream m_*: one word per window, mean_q8 in [19:0], ph_milli in [35:20].
// Path: a closed window is written into the queue, then passes the back stages s1-s4 and the output register.
// Throughput: one sample per cycle; one result per cycle peak, set by the
// five-stage back pipe which advances as a whole.
// Config: cfg_we/cfg_index/cfg_wdata, 0 = ph_gain, 1 = ph_offset_milli (low
// 15 bits). Write only while idle; other indexes are ignored.
// Reset: window cleared, queue empty, gain 294697, offset 0.
// Stall: m_tready low holds the output word; the back pipe freezes, the queue
// fills, and only then does s_tready go low.
`default_nettype none

module trimmed_mean_ph_sampler_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [tmps_pkg::S_TDATA_W-1:0]    s_tdata,   // [11:0] sample
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [tmps_pkg::M_TDATA_W-1:0]         m_tdata,   // [19:0] mean_q8, [35:20] ph_milli
	input  wire logic                              cfg_we,
	input  wire logic [tmps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tmps_pkg::GAIN_W-1:0]       cfg_wdata
);
	import tmps_pkg::*;

	logic [GAIN_W-1:0] gain_q;
	logic [OFFS_W-1:0] offset_q;

	logic    take;
	logic    push;
	window_t push_win;
	window_t head_win;
	logic    q_empty;
	logic    q_full;
	logic    pop;

	logic [Q8_W-1:0] mean_q8;
	logic [PH_W-1:0] ph_milli;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RESET;
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PH_GAIN:   gain_q   <= cfg_wdata;
				CFG_PH_OFFSET: offset_q <= cfg_wdata[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_tready = !q_full;
	assign take     = s_tvalid && s_tready;

	tmps_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.sample (s_tdata[SAMPLE_W-1:0]),
		.push   (push),
		.win    (push_win)
	);

	tmps_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_win (push_win),
		.pop    (pop),
		.rd_win (head_win),
		.empty  (q_empty),
		.full   (q_full)
	);

	tmps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (head_win),
		.win_avail (!q_empty),
		.win_pop   (pop),
		.gain      (gain_q),
		.offset    (offset_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.mean_q8   (mean_q8),
		.ph_milli  (ph_milli)
	);

	assign m_tdata = {(M_TDATA_W - Q8_W - PH_W)'(0), ph_milli, mean_q8};

endmodule

`default_nettype wire

/* src/tmps_checker.sv */
`default_nettype none

module tmps_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [tmps_pkg::M_TDATA_W-1:0] m_tdata
);
	import tmps_pkg::*;

	// a mean never exceeds the largest code with 8 fraction bits
	localparam logic [Q8_W-1:0] MEAN_MAX = Q8_W'(4095 * 256);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("output word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output word changed while stalled");

	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[Q8_W-1:0] <= MEAN_MAX)
		else $error("mean above full scale");

	a_ph_floor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[Q8_W+PH_W-1:Q8_W]) >= -16'sd16384)
		else $error("pH below most negative offset");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:Q8_W+PH_W] == '0)
		else $error("pad bits set");

endmodule

bind trimmed_mean_ph_sampler_unit tmps_checker u_tmps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

/* test/tb.sv */
`default_nettype none

module tb;
	import tmps_pkg::*;

	typedef logic [SAMPLE_W-1:0] sample_t;

	// one expected output word
	typedef struct packed {
		logic [Q8_W-1:0]        mean_q8;
		logic signed [PH_W-1:0] ph_milli;
	} window_result_t;

	// how the samples of one window are drawn
	typedef enum int {
		FILL_UNIFORM,
		FILL_NARROW,
		FILL_RAILS,
		FILL_BITS,
		FILL_CONST,
		FILL_SPAN
	} fill_t;

	localparam sample_t           SAMPLE_MAX = '1;
	localparam logic [GAIN_W-1:0] GAIN_MAX   = '1;
	localparam int                OFFS_LIMIT = 16000;
	localparam int                PH_HI      = 32767;
	localparam int                PH_LO      = -32768;
	// indexes past the two registers; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
	// margin for the pipe to go quiet once every result is out
	localparam int SETTLE_CYCLES = 16;
	localparam int HANG_LIMIT    = 4000;
	localparam int RAND_WINDOWS  = 28;
	localparam int PHASE_WINDOWS = 6;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;    // [11:0] sample
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;    // [19:0] mean_q8, [35:20] ph_milli
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [GAIN_W-1:0]    cfg_wdata;

	trimmed_mean_ph_sampler_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// mirror of the block: registers and the open window
	logic [GAIN_W-1:0]        gain_reg;
	logic signed [OFFS_W-1:0] offs_reg;
	logic [CNT_W-1:0]         win_count;
	logic [SUM_W-1:0]         win_sum;
	sample_t                  win_min;
	sample_t                  win_max;

	window_result_t pending_results[$];

	int  mismatches   = 0;
	int  samples_sent = 0;
	int  results_seen = 0;
	int  reg_writes   = 0;
	int  hang_count   = 0;
	bit  src_gaps     = 1'b0;
	bit  sink_stalls  = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// most gaps are a few cycles, about one in twenty is long
	function automatic int gap_len();
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(12, 48);
		return $urandom_range(0, 3);
	endfunction

	task automatic report(input string what);
		$display("ERROR at %0t: %s", $time, what);
		mismatches++;
	endtask

	task automatic clear_window();
		win_count = '0;
		win_sum   = '0;
		win_min   = SAMPLE_MAX;
		win_max   = '0;
	endtask

	// window accumulator; on the closing sample works out mean and pH
	task automatic accumulate_sample(input sample_t smp);
		longint trimmed;
		longint mean;
		longint ph;
		window_result_t res;
		win_sum = win_sum + SUM_W'(smp);
		if (smp < win_min)
			win_min = smp;
		if (smp > win_max)
			win_max = smp;
		win_count = win_count + 1'b1;
		if (int'(win_count) < WINDOW)
			return;
		if (!TRIM) begin
			mean = (longint'(win_sum) / WINDOW) << 8;
		end else begin
			// one copy of min and of max goes, even when they are equal
			trimmed = longint'(win_sum) - longint'(win_min) - longint'(win_max);
			mean = (trimmed << 8) / (WINDOW - 2);
		end
		mean = mean & ((longint'(1) << Q8_W) - 1);
		ph = ((mean * longint'(gain_reg)) >> 24) + longint'(offs_reg);
		if (ph > PH_HI)
			ph = PH_HI;
		if (ph < PH_LO)
			ph = PH_LO;
		res.mean_q8  = Q8_W'(mean);
		res.ph_milli = PH_W'(ph);
		pending_results.push_back(res);
		clear_window();
	endtask

	// one word into s_*; valid stays high into the next call unless a gap is drawn
	task automatic push_sample(input sample_t smp);
		int gap;
		gap = src_gaps ? gap_len() : 0;
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'(smp);
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		accumulate_sample(smp);
		samples_sent++;
	endtask

	// register write, one cycle of cfg_we
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		if (idx == CFG_PH_GAIN)
			gain_reg = data;
		else if (idx == CFG_PH_OFFSET)
			offs_reg = data[OFFS_W-1:0];
		reg_writes++;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender holds off until every result is out, then lets the pipe go quiet
	task automatic settle_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic send_window(input fill_t how, input sample_t level);
		sample_t smp;
		int      k;
		int      d;
		for (k = 0; k < WINDOW; k++) begin
			case (how)
				FILL_CONST: begin
					smp = level;
				end
				FILL_NARROW: begin
					// probe noise around a steady level
					d = int'($urandom_range(0, 32)) - 16 + int'(level);
					if (d < 0)
						d = 0;
					if (d > int'(SAMPLE_MAX))
						d = int'(SAMPLE_MAX);
					smp = sample_t'(d);
				end
				FILL_RAILS: begin
					smp = $urandom_range(0, 1) ? SAMPLE_MAX : sample_t'(0);
				end
				FILL_BITS: begin
					smp = sample_t'(1) << $urandom_range(0, SAMPLE_W - 1);
					if ($urandom_range(0, 1))
						smp = ~smp;
				end
				FILL_SPAN: begin
					// floor first, ceiling last, anything between
					if (k == 0)
						smp = '0;
					else if (k == WINDOW - 1)
						smp = SAMPLE_MAX;
					else
						smp = sample_t'($urandom_range(0, int'(SAMPLE_MAX)));
				end
				default: begin
					smp = sample_t'($urandom_range(0, int'(SAMPLE_MAX)));
				end
			endcase
			push_sample(smp);
		end
	endtask

	task automatic test_reset_defaults();
		src_gaps    = 1'b0;
		sink_stalls = 1'b0;
		send_window(FILL_SPAN, '0);
	endtask

	task automatic test_equal_samples();
		src_gaps    = 1'b1;
		sink_stalls = 1'b1;
		send_window(FILL_CONST, sample_t'($urandom_range(1, int'(SAMPLE_MAX) - 1)));
		send_window(FILL_CONST, '0);
	endtask

	task automatic test_saturation();
		settle_idle();
		// biggest mean times biggest gain runs past the top of 16 bits
		write_reg(CFG_PH_GAIN, GAIN_MAX);
		write_reg(CFG_PH_OFFSET, GAIN_W'(OFFS_LIMIT));
		send_window(FILL_CONST, SAMPLE_MAX);
		settle_idle();
		write_reg(CFG_PH_GAIN, '0);
		write_reg(CFG_PH_OFFSET, GAIN_W'(-OFFS_LIMIT));
		send_window(FILL_RAILS, '0);
	endtask

	task automatic test_spare_index();
		settle_idle();
		write_reg(CFG_PH_GAIN, GAIN_RESET);
		write_reg(CFG_SPARE_LO, GAIN_W'($urandom()));
		write_reg(CFG_SPARE_HI, GAIN_W'($urandom()));
		send_window(FILL_UNIFORM, '0);
	endtask

	task automatic test_random_windows();
		int w;
		int off;
		for (w = 0; w < RAND_WINDOWS; w++) begin
			if (w % PHASE_WINDOWS == 0) begin
				settle_idle();
				// second phase runs flat out on both sides
				src_gaps    = (w != PHASE_WINDOWS) && ($urandom_range(0, 3) != 0);
				sink_stalls = (w != PHASE_WINDOWS) && ($urandom_range(0, 3) != 0);
				case ($urandom_range(0, 3))
					0:       write_reg(CFG_PH_GAIN, '0);
					1:       write_reg(CFG_PH_GAIN, GAIN_MAX);
					2:       write_reg(CFG_PH_GAIN, GAIN_RESET);
					default: write_reg(CFG_PH_GAIN, GAIN_W'($urandom()));
				endcase
				case ($urandom_range(0, 3))
					0:       off = -OFFS_LIMIT;
					1:       off = OFFS_LIMIT;
					2:       off = 0;
					default: off = int'($urandom_range(0, 2 * OFFS_LIMIT)) - OFFS_LIMIT;
				endcase
				write_reg(CFG_PH_OFFSET, GAIN_W'(off));
			end
			send_window(fill_t'($urandom_range(int'(FILL_UNIFORM), int'(FILL_BITS))),
				sample_t'($urandom_range(0, int'(SAMPLE_MAX))));
		end
	endtask

	// sink side: random back-pressure on m_tready, driven on falling edges
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_stalls && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result checker: every output word against the oldest expectation
	always @(posedge clk) begin
		window_result_t want;
		logic [Q8_W-1:0]        got_mean;
		logic signed [PH_W-1:0] got_ph;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			got_mean = m_tdata[Q8_W-1:0];
			got_ph   = m_tdata[Q8_W +: PH_W];
			results_seen++;
			if (pending_results.size() == 0) begin
				report($sformatf("unexpected word: mean_q8 %0d ph_milli %0d",
					got_mean, got_ph));
			end else begin
				want = pending_results.pop_front();
				if (got_mean !== want.mean_q8)
					report($sformatf("mean_q8 got %0d want %0d", got_mean, want.mean_q8));
				if (got_ph !== want.ph_milli)
					report($sformatf("ph_milli got %0d want %0d", got_ph, want.ph_milli));
			end
		end
	end

	// watchdog: too long with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid === 1'b1 && m_tready)) begin
			hang_count <= 0;
		end else if (hang_count >= HANG_LIMIT) begin
			$display("Timeout: no handshake for %0d cycles", hang_count);
			$display("Mismatches found");
			$finish;
		end else begin
			hang_count <= hang_count + 1;
		end
	end

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_PH_GAIN;
		cfg_wdata = '0;
		gain_reg  = GAIN_RESET;
		offs_reg  = '0;
		clear_window();
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_equal_samples();
		test_saturation();
		test_spare_index();
		test_random_windows();

		// drain and watch for stray words
		settle_idle();
		if (pending_results.size() != 0)
			report($sformatf("%0d results never arrived", pending_results.size()));

		$display("Ran %0d samples, checked %0d window results, %0d register writes",
			samples_sent, results_seen, reg_writes);
		$display("Covered rails, equal samples, clamping, spare indexes, stalls on both ports");
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
src/tmps_pkg.sv
src/tmps_front.sv
src/tmps_fifo.sv
src/tmps_back.sv
src/trimmed_mean_ph_sampler_unit.sv
src/tmps_checker.sv
test/tb.sv
